>>> src/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg: shared types and constants for the sampling block
// Widths, status and request codes, channel payloads and sequencer states.
// ----------------------------------------------------------------------------
package swr_pkg;

    localparam int MAX_COUNT  = 1024;
    localparam int VALUE_BITS = 16;
    localparam int BOUND_W    = 16;
    localparam int RND_W      = 31;
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);
    localparam int ADDR_W     = $clog2(MAX_COUNT);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BOUND_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 1'b1;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_DRAW  = 1'b1
    } swr_req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } swr_status_t;

    typedef struct packed {
        swr_req_kind_t    req_type;
        logic [RND_W-1:0] random_word;
        logic             last_draw;
    } swr_req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] drawn_value;
        swr_status_t           status;
        logic [CNT_W-1:0]      remaining_count;
    } swr_rsp_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] remainder;
    } swr_mod_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_MOD,
        S_READ,
        S_TAKE,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } swr_state_t;

endpackage

>>> src/swr_req_if.sv
// ----------------------------------------------------------------------------
// swr_req_if: request channel
// Valid/ready channel carrying start and draw requests.
// ----------------------------------------------------------------------------
interface swr_req_if
    import swr_pkg::*;
();
    logic     valid;
    logic     ready;
    swr_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/swr_rsp_if.sv
// ----------------------------------------------------------------------------
// swr_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface swr_rsp_if
    import swr_pkg::*;
();
    logic     valid;
    logic     ready;
    swr_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/swr_ram.sv
// ----------------------------------------------------------------------------
// swr_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> src/swr_mod_unit.sv
// ----------------------------------------------------------------------------
// swr_mod_unit: iterative modulo unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module swr_mod_unit
    import swr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output swr_mod_res_t     res
);
    localparam int TRIAL_W = ADDR_W + 1;
    localparam int ITER_W  = $clog2(RND_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [RND_W-1:0]    dvd_reg, dvd_next;
    logic [ADDR_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]    dsr_reg, dsr_next;
    logic [TRIAL_W-1:0]  trial;
    logic [TRIAL_W-1:0]  dsr_ext;

    assign dsr_ext = TRIAL_W'(dsr_reg);
    assign trial   = {rem_reg, dvd_reg[RND_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(RND_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            if (trial >= dsr_ext)
            begin
                rem_next = ADDR_W'(trial - dsr_ext);
            end
            else
            begin
                rem_next = ADDR_W'(trial);
            end
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res.done      = done_reg;
    assign res.remainder = rem_reg;
endmodule

>>> src/sample_without_replacement_list.sv
// ----------------------------------------------------------------------------
// sample_without_replacement_list: draw distinct values without repeats
// Ordered value list in a RAM, iterative modulo unit and a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Write low_bound (index CFG_LOW) and high_bound (index CFG_HIGH) on the
//   cfg port while the block is idle. Send a start request on req to load the
//   list with low_bound..high_bound; send draw requests with a random word to
//   take values. Every request yields exactly one transfer on rsp.
// Sequence per request (request accept to response valid):
//   start, good bounds : one RAM write per entry, then the response
//   start, bad bounds, or draw from an empty list : straight to the response
//   draw : the bit-serial modulo, then the entry read, then each entry
//          behind the gap (remaining - 1 - index entries) moves up one
//          place, with a RAM read and then a RAM write per entry.
// Only one request is in flight; req.ready is high only while idle. A
// finished response sits in the output register, so the next request is
// taken while the receiver stalls; a second response waits until the
// first one transfers.
// Reset empties the list (spent, count zero) and sets both bounds to one; the
// RAM content is not cleared, entries are written by a start before use.
// ----------------------------------------------------------------------------
module sample_without_replacement_list
    import swr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    swr_req_if.sink               req,
    swr_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int DIFF_W = BOUND_W + 1;

    swr_state_t state_reg, state_next;

    // configuration
    logic [BOUND_W-1:0] low_reg, high_reg;

    // list state
    logic [CNT_W-1:0]      remaining_reg, remaining_next;
    logic                  spent_reg, spent_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [VALUE_BITS-1:0] fill_val_reg, fill_val_next;
    logic                  last_reg, last_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;

    // pending result
    swr_rsp_t res_reg, res_next;

    // output register
    logic     rsp_valid_reg, rsp_valid_next;
    swr_rsp_t rsp_data_reg, rsp_data_next;

    // shared units
    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;
    logic                  mod_start;
    swr_mod_res_t          mod_res;

    // bound check and sequencer conditions
    logic [DIFF_W-1:0] diff;
    logic              bad_bounds;
    logic [CNT_W-1:0]  range_count;
    logic              accept;
    logic              fill_last;
    logic              shift_more;
    logic              out_free;

    assign diff        = {1'b0, high_reg} - {1'b0, low_reg};
    assign bad_bounds  = diff[DIFF_W-1] || (64'(diff) >= 64'(MAX_COUNT));
    assign range_count = CNT_W'(64'(diff) + 64'd1);
    assign accept      = req.valid && req.ready;
    assign fill_last   = (CNT_W'(ptr_reg) + 1'b1) == remaining_reg;
    assign shift_more  = (CNT_W'(ptr_reg) + 1'b1) < remaining_reg;
    assign out_free    = !rsp_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    swr_ram #(
        .DEPTH (MAX_COUNT),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swr_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (req.data.random_word),
        .divisor  (remaining_reg),
        .res      (mod_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.req_type == REQ_START)
                    begin
                        state_next = bad_bounds ? S_RESP : S_FILL;
                    end
                    else if (spent_reg || (remaining_reg == '0))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_FILL:
            begin
                if (fill_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_MOD:
            begin
                if (mod_res.done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_TAKE;
            S_TAKE:  state_next = S_SH_RD;
            S_SH_RD: state_next = shift_more ? S_SH_WR : S_RESP;
            S_SH_WR: state_next = S_SH_RD;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // datapath and unit controls
    always_comb
    begin
        remaining_next = remaining_reg;
        spent_next     = spent_reg;
        ptr_next       = ptr_reg;
        fill_val_next  = fill_val_reg;
        last_next      = last_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_raddr      = ptr_reg;
        ram_wdata      = ram_rdata;
        mod_start      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.req_type == REQ_START)
                    begin
                        if (bad_bounds)
                        begin
                            remaining_next = '0;
                            spent_next     = 1'b1;
                            res_next       = '{drawn_value: '0, status: ST_BAD,
                                               remaining_count: '0};
                        end
                        else
                        begin
                            remaining_next = range_count;
                            spent_next     = 1'b0;
                            ptr_next       = '0;
                            fill_val_next  = VALUE_BITS'(low_reg);
                            res_next       = '{drawn_value: '0, status: ST_OK,
                                               remaining_count: range_count};
                        end
                    end
                    else if (spent_reg || (remaining_reg == '0))
                    begin
                        res_next = '{drawn_value: '0, status: ST_EMPTY,
                                     remaining_count: '0};
                    end
                    else
                    begin
                        mod_start = 1'b1;
                        last_next = req.data.last_draw;
                    end
                end
            end
            S_FILL:
            begin
                // write the range in increasing order, one entry a cycle
                ram_we        = 1'b1;
                ram_wdata     = fill_val_reg;
                ptr_next      = ptr_reg + 1'b1;
                fill_val_next = fill_val_reg + 1'b1;
            end
            S_MOD:
            begin
                if (mod_res.done)
                begin
                    ptr_next = mod_res.remainder;
                end
            end
            S_READ:
            begin
                ram_re = 1'b1;
            end
            S_TAKE:
            begin
                val_next = ram_rdata;
            end
            S_SH_RD:
            begin
                if (shift_more)
                begin
                    // fetch the entry behind the gap
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + 1'b1;
                end
                else
                begin
                    remaining_next = last_reg ? '0 : (remaining_reg - 1'b1);
                    spent_next     = last_reg ? 1'b1 : spent_reg;
                    res_next       = '{drawn_value: val_reg, status: ST_OK,
                                       remaining_count:
                                           last_reg ? '0 : (remaining_reg - 1'b1)};
                end
            end
            S_SH_WR:
            begin
                // move it one place forward
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_reg + 1'b1;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            low_reg       <= BOUND_W'(1);
            high_reg      <= BOUND_W'(1);
            remaining_reg <= '0;
            spent_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            spent_reg     <= spent_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOW:  low_reg  <= cfg_data;
                    CFG_HIGH: high_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        fill_val_reg <= fill_val_next;
        last_reg     <= last_next;
        val_reg      <= val_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end
endmodule

>>> src/swr_checker.sv
// ----------------------------------------------------------------------------
// swr_checker: port-level checks for the sampling block
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module swr_checker
    import swr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [VALUE_BITS-1:0] rsp_value,
    input logic [1:0]            rsp_status,
    input logic [CNT_W-1:0]      rsp_count
);
    // hold the response until it transfers
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
            && $stable(rsp_status) && $stable(rsp_count))
        else $error("response dropped or changed while stalled");

    // drop ready for the request in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_BAD)
            |-> rsp_value == '0 && rsp_count == '0)
        else $error("failed response carries a value or a count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 64'(rsp_count) <= 64'(MAX_COUNT)
            && (rsp_status == ST_OK || rsp_status == ST_EMPTY
                || rsp_status == ST_BAD))
        else $error("response count or status out of range");
endmodule

bind sample_without_replacement_list swr_checker u_swr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_value  (rsp.data.drawn_value),
    .rsp_status (rsp.data.status),
    .rsp_count  (rsp.data.remaining_count)
);
